[hdl/mseu_pkg.sv]
// Package for the MIPS subset execute unit: opcodes, function codes,
// controller command/status structs and sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mseu_pkg;
    localparam int DATA_WORDS = 1024;
    localparam int DADDR_W = $clog2(DATA_WORDS);

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1A;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_SLT  = 6'h2A;

    // controller -> datapath
    typedef struct packed {
        logic load_ir;    // capture instruction, start register read
        logic exec;       // compute result, issue memory access
        logic div_start;  // start iterative divide
        logic commit;     // write back, update pc, load output register
    } mseu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_div;
        logic div_done;
    } mseu_sts_t;
endpackage
`default_nettype wire

[hdl/mseu_div.sv]
// Signed 32-bit iterative divider, one quotient bit per cycle.
// Depends on nothing beyond its ports.
`timescale 1ns / 1ps
`default_nettype none
module mseu_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quot,
    output logic [31:0]      rem
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        qneg_reg, qneg_next, rneg_reg, rneg_next;
    logic [32:0] trial;

    always_comb begin
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        qneg_next = qneg_reg; rneg_next = rneg_reg;
        trial = {r_reg[31:0], q_reg[31]} - {1'b0, d_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            q_next    = dividend[31] ? (~dividend + 32'd1) : dividend;
            d_next    = divisor[31] ? (~divisor + 32'd1) : divisor;
            r_next    = '0;
            qneg_next = dividend[31] ^ divisor[31];
            rneg_next = dividend[31];
        end else if (busy_reg) begin
            if (!trial[32]) begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = {r_reg[31:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
        qneg_reg <= qneg_next; rneg_reg <= rneg_next;
    end

    assign done = done_reg;
    assign quot = qneg_reg ? (~q_reg + 32'd1) : q_reg;
    assign rem  = rneg_reg ? (~r_reg[31:0] + 32'd1) : r_reg[31:0];
endmodule
`default_nettype wire

[hdl/mseu_datapath.sv]
// Datapath: register file, HI/LO, PC, data memory, ALU, multiplier,
// divider and result register. Uses mseu_pkg and mseu_div.
`timescale 1ns / 1ps
`default_nettype none
module mseu_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mseu_pkg::mseu_cmd_t cmd,
    output mseu_pkg::mseu_sts_t      sts,
    input  wire logic [31:0]         instr_word,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_wdata,
    output logic [31:0]              start_addr,
    output logic [31:0]              next_pc,
    output logic                     reg_write,
    output logic [4:0]               reg_index,
    output logic [31:0]              reg_value,
    output logic                     mem_write,
    output logic [31:0]              mem_address,
    output logic [31:0]              mem_data,
    output logic                     recognized
);
    logic [31:0] ir_reg;
    logic [31:0] a_reg, b_reg;
    logic [31:0] start_reg, pc_reg, hi_reg, lo_reg;
    logic [31:0] gpr_reg [32];
    logic [31:0] dmem [mseu_pkg::DATA_WORDS];
    logic [31:0] ld_reg;
    logic [63:0] prod_reg;
    // execute results held for commit
    logic        wr_reg, mw_reg, rec_reg, mul_reg, div_reg, ld_sel_reg;
    logic [4:0]  widx_reg;
    logic [31:0] wval_reg, npc_reg, maddr_reg;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [31:0] simm, pc4, btgt, jtgt, maddr;
    logic [63:0] rot;
    logic        wr, mw, rec;
    logic [4:0]  widx;
    logic [31:0] wval, npc;
    logic        div_done;
    logic [31:0] quot, rem;
    logic [31:0] fin_val, fin_mdata;
    logic        fin_wr;

    assign op   = ir_reg[31:26];
    assign rs   = ir_reg[25:21];
    assign rt   = ir_reg[20:16];
    assign rd   = ir_reg[15:11];
    assign sa   = ir_reg[10:6];
    assign fn   = ir_reg[5:0];
    assign simm = {{16{ir_reg[15]}}, ir_reg[15:0]};
    assign pc4  = pc_reg + 32'd4;
    assign btgt = pc4 + {simm[29:0], 2'b00};
    assign jtgt = {pc4[31:28], ir_reg[25:0], 2'b00};
    assign maddr = a_reg + simm;
    assign rot  = {b_reg, b_reg} >> sa;

    always_comb begin
        wr = 1'b0; mw = 1'b0; rec = 1'b1; widx = rd; wval = '0; npc = pc4;
        if (op == mseu_pkg::OP_SPECIAL) begin
            unique case (fn)
                mseu_pkg::FN_ADD: begin wr = 1'b1; wval = a_reg + b_reg; end
                mseu_pkg::FN_SUB: begin wr = 1'b1; wval = a_reg - b_reg; end
                mseu_pkg::FN_AND: begin wr = 1'b1; wval = a_reg & b_reg; end
                mseu_pkg::FN_OR:  begin wr = 1'b1; wval = a_reg | b_reg; end
                mseu_pkg::FN_XOR: begin wr = 1'b1; wval = a_reg ^ b_reg; end
                mseu_pkg::FN_SLL: begin wr = 1'b1; wval = b_reg << sa; end
                mseu_pkg::FN_SRL: begin
                    wr = 1'b1;
                    wval = (rs == 5'd1) ? rot[31:0] : (b_reg >> sa);
                end
                mseu_pkg::FN_SLT: begin
                    wr = 1'b1;
                    wval = {31'd0, $signed(a_reg) < $signed(b_reg)};
                end
                mseu_pkg::FN_MFHI: begin wr = 1'b1; wval = hi_reg; end
                mseu_pkg::FN_MFLO: begin wr = 1'b1; wval = lo_reg; end
                mseu_pkg::FN_JR:   npc = a_reg;
                mseu_pkg::FN_MULT, mseu_pkg::FN_DIV: ;
                default: rec = 1'b0;
            endcase
        end else begin
            widx = rt;
            unique case (op)
                mseu_pkg::OP_ADDI: begin wr = 1'b1; wval = maddr; end
                mseu_pkg::OP_LW:   wr = 1'b1;
                mseu_pkg::OP_SW:   mw = 1'b1;
                mseu_pkg::OP_LUI:  begin wr = 1'b1; wval = {ir_reg[15:0], 16'd0}; end
                mseu_pkg::OP_BEQ:  if (a_reg == b_reg) npc = btgt;
                mseu_pkg::OP_BNE:  if (a_reg != b_reg) npc = btgt;
                mseu_pkg::OP_BGTZ: if ($signed(a_reg) > 0) npc = btgt;
                mseu_pkg::OP_BLEZ: if ($signed(a_reg) <= 0) npc = btgt;
                mseu_pkg::OP_J:    npc = jtgt;
                mseu_pkg::OP_JAL:  begin wr = 1'b1; widx = 5'd31; wval = pc4; npc = jtgt; end
                default: rec = 1'b0;
            endcase
        end
    end

    mseu_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(a_reg), .divisor(b_reg),
        .done(div_done), .quot(quot), .rem(rem)
    );

    assign sts.is_div   = (op == mseu_pkg::OP_SPECIAL) && (fn == mseu_pkg::FN_DIV);
    assign sts.div_done = div_done;

    assign fin_val   = ld_sel_reg ? ld_reg : wval_reg;
    assign fin_mdata = ld_sel_reg ? ld_reg : (mw_reg ? b_reg : 32'd0);
    assign fin_wr    = wr_reg && (widx_reg != 5'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            pc_reg    <= '0;
            hi_reg    <= '0;
            lo_reg    <= '0;
            for (int i = 0; i < 32; i++) gpr_reg[i] <= '0;
        end else begin
            if (cfg_we) begin
                start_reg <= cfg_wdata;
                pc_reg    <= {cfg_wdata[31:2], 2'b00};
            end
            if (cmd.commit) begin
                pc_reg <= npc_reg;
                if (fin_wr) gpr_reg[widx_reg] <= fin_val;
                if (mul_reg) begin
                    hi_reg <= prod_reg[63:32];
                    lo_reg <= prod_reg[31:0];
                end else if (div_reg) begin
                    if (b_reg == 32'd0) begin
                        hi_reg <= a_reg;
                        lo_reg <= 32'hFFFF_FFFF;
                    end else begin
                        hi_reg <= rem;
                        lo_reg <= quot;
                    end
                end
            end
        end
        if (cmd.load_ir) ir_reg <= instr_word;
        a_reg <= gpr_reg[rs];
        b_reg <= gpr_reg[rt];
        if (cmd.exec) begin
            prod_reg   <= $signed(a_reg) * $signed(b_reg);
            wr_reg     <= wr;
            mw_reg     <= mw;
            rec_reg    <= rec;
            widx_reg   <= widx;
            wval_reg   <= wval;
            npc_reg    <= npc;
            maddr_reg  <= (op == mseu_pkg::OP_LW || op == mseu_pkg::OP_SW) ? maddr : 32'd0;
            ld_sel_reg <= (op == mseu_pkg::OP_LW);
            mul_reg    <= (op == mseu_pkg::OP_SPECIAL) && (fn == mseu_pkg::FN_MULT);
            div_reg    <= sts.is_div;
        end
        if (cmd.commit) begin
            next_pc     <= npc_reg;
            reg_write   <= fin_wr;
            reg_index   <= fin_wr ? widx_reg : 5'd0;
            reg_value   <= fin_wr ? fin_val : 32'd0;
            mem_write   <= mw_reg;
            mem_address <= maddr_reg;
            mem_data    <= fin_mdata;
            recognized  <= rec_reg;
        end
    end

    // data memory: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.exec && mw) dmem[maddr[mseu_pkg::DADDR_W+1:2]] <= b_reg;
        ld_reg <= dmem[maddr[mseu_pkg::DADDR_W+1:2]];
    end

    assign start_addr = start_reg;
endmodule
`default_nettype wire

[hdl/mseu_ctrl.sv]
// Controller FSM: sequences fetch, decode, execute, (divide), commit and
// the output handshake. Uses mseu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mseu_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire mseu_pkg::mseu_sts_t sts,
    output mseu_pkg::mseu_cmd_t      cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MEM  = 3'd4;
    localparam logic [2:0] ST_CMT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;
    logic       can_commit;

    // result register may load when empty or being drained
    assign can_commit = !mv_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: if (s_valid) begin
                cmd.load_ir = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.is_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_MEM;
                end
            end
            ST_DIV: if (sts.div_done) state_next = ST_CMT;
            ST_MEM: state_next = ST_CMT;
            ST_CMT: if (can_commit) begin
                cmd.commit = 1'b1;
                mv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!mv_reg || m_ready)) else $error("commit over pending result");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_ir, cmd.exec, cmd.commit})) else $error("overlapping commands");
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid) else $error("commit without result valid");
endmodule
`default_nettype wire

[hdl/mips_subset_execute_unit_top.sv]
// MIPS subset execute unit top: controller + datapath + APB register port.
// Uses mseu_pkg, mseu_ctrl, mseu_datapath.
// Sequence: read, execute, memory and commit states after acceptance; DIV
//   waits in a divide state instead of memory until the bit-serial divider
//   is done. One item in flight at a time.
// Reset (aresetn, sync, low): registers, HI, LO, PC and start_address clear;
//   data memory is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module mips_subset_execute_unit_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_instr_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_next_pc,
    output logic             m_reg_write,
    output logic [4:0]       m_reg_index,
    output logic [31:0]      m_reg_value,
    output logic             m_mem_write,
    output logic [31:0]      m_mem_address,
    output logic [31:0]      m_mem_data,
    output logic             m_recognized
);
    mseu_pkg::mseu_cmd_t cmd;
    mseu_pkg::mseu_sts_t sts;
    logic [31:0] start_addr;
    logic        cfg_we;

    // single register at address 0; write also reloads the PC
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? start_addr : 32'd0;

    mseu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    mseu_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .instr_word(s_instr_word),
        .cfg_we(cfg_we), .cfg_wdata(pwdata), .start_addr(start_addr),
        .next_pc(m_next_pc), .reg_write(m_reg_write), .reg_index(m_reg_index),
        .reg_value(m_reg_value), .mem_write(m_mem_write),
        .mem_address(m_mem_address), .mem_data(m_mem_data),
        .recognized(m_recognized)
    );
endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for mips_subset_execute_unit_top.
// Depends on mseu_pkg and the top module; predicts every result with an
// in-bench instruction executor and checks it field by field.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] REG_START_ADDRESS = 2'd0;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
        logic        recognized;
    } exec_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_instr_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    exec_result_t got;

    mips_subset_execute_unit_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_instr_word(s_instr_word),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_next_pc(got.next_pc), .m_reg_write(got.reg_write),
        .m_reg_index(got.reg_index), .m_reg_value(got.reg_value),
        .m_mem_write(got.mem_write), .m_mem_address(got.mem_address),
        .m_mem_data(got.mem_data), .m_recognized(got.recognized)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Architectural shadow state of the predictor.
    logic [31:0] arch_regs [32];
    logic [31:0] arch_hi, arch_lo, arch_pc;
    logic [31:0] arch_mem [mseu_pkg::DATA_WORDS];
    bit          arch_mem_written [mseu_pkg::DATA_WORDS];
    exec_result_t pending_results [$];

    int  send_idle_pct = 0;   // sender gap chance, percent
    int  recv_stall_pct = 0;  // receiver stall chance, percent
    int  hold_off_cycles = 0; // long receiver hold-off, counted down in the stall generator
    int  quiet_cycles = 0;
    bit  failed = 0;

    function automatic logic [31:0] sext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic int unsigned mem_slot(logic [31:0] addr);
        return (addr >> 2) % mseu_pkg::DATA_WORDS;
    endfunction

    // Executes one instruction on the shadow state and returns its result.
    function automatic exec_result_t execute_instr(logic [31:0] iw);
        exec_result_t r;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sa;
        logic [31:0] a, b, pc4, boff, jtgt;
        logic signed [63:0] prod, sx, sy;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
        op = iw[31:26]; rs = iw[25:21]; rt = iw[20:16];
        rd = iw[15:11]; sa = iw[10:6];  fn = iw[5:0];
        a = arch_regs[rs]; b = arch_regs[rt];
        pc4 = arch_pc + 32'd4;
        boff = sext16(iw[15:0]) << 2;
        jtgt = {pc4[31:28], iw[25:0], 2'b00};
        r = '0;
        r.next_pc = pc4;
        r.recognized = 1'b1;
        wr = 0; widx = 0; wval = 0;
        if (op == mseu_pkg::OP_SPECIAL) begin
            case (fn)
                mseu_pkg::FN_ADD:  begin wr = 1; widx = rd; wval = a + b; end
                mseu_pkg::FN_SUB:  begin wr = 1; widx = rd; wval = a - b; end
                mseu_pkg::FN_AND:  begin wr = 1; widx = rd; wval = a & b; end
                mseu_pkg::FN_OR:   begin wr = 1; widx = rd; wval = a | b; end
                mseu_pkg::FN_XOR:  begin wr = 1; widx = rd; wval = a ^ b; end
                mseu_pkg::FN_SLL:  begin wr = 1; widx = rd; wval = b << sa; end
                mseu_pkg::FN_SRL: begin
                    wr = 1; widx = rd; wval = b >> sa;
                    if (rs == 5'd1 && sa != 0) wval |= b << (6'd32 - sa);
                end
                mseu_pkg::FN_SLT: begin
                    wr = 1; widx = rd; wval = {31'd0, $signed(a) < $signed(b)};
                end
                mseu_pkg::FN_MFHI: begin wr = 1; widx = rd; wval = arch_hi; end
                mseu_pkg::FN_MFLO: begin wr = 1; widx = rd; wval = arch_lo; end
                mseu_pkg::FN_JR:   r.next_pc = a;
                mseu_pkg::FN_MULT: begin
                    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    arch_hi = prod[63:32]; arch_lo = prod[31:0];
                end
                mseu_pkg::FN_DIV: begin
                    if (b == 0) begin
                        arch_hi = a; arch_lo = 32'hFFFF_FFFF;
                    end else begin
                        sx = $signed({{32{a[31]}}, a});
                        sy = $signed({{32{b[31]}}, b});
                        prod = sx % sy; arch_hi = prod[31:0];
                        prod = sx / sy; arch_lo = prod[31:0];
                    end
                end
                default: r.recognized = 1'b0;
            endcase
        end else begin
            case (op)
                mseu_pkg::OP_ADDI: begin
                    wr = 1; widx = rt; wval = a + sext16(iw[15:0]);
                end
                mseu_pkg::OP_LW: begin
                    r.mem_address = a + sext16(iw[15:0]);
                    r.mem_data = arch_mem[mem_slot(r.mem_address)];
                    wr = 1; widx = rt; wval = r.mem_data;
                end
                mseu_pkg::OP_SW: begin
                    r.mem_address = a + sext16(iw[15:0]);
                    r.mem_data = b;
                    r.mem_write = 1'b1;
                    arch_mem[mem_slot(r.mem_address)] = b;
                    arch_mem_written[mem_slot(r.mem_address)] = 1;
                end
                mseu_pkg::OP_LUI:  begin wr = 1; widx = rt; wval = {iw[15:0], 16'd0}; end
                mseu_pkg::OP_BEQ:  if (a == b) r.next_pc = pc4 + boff;
                mseu_pkg::OP_BNE:  if (a != b) r.next_pc = pc4 + boff;
                mseu_pkg::OP_BGTZ: if ($signed(a) > 0) r.next_pc = pc4 + boff;
                mseu_pkg::OP_BLEZ: if ($signed(a) <= 0) r.next_pc = pc4 + boff;
                mseu_pkg::OP_J:    r.next_pc = jtgt;
                mseu_pkg::OP_JAL: begin
                    wr = 1; widx = 5'd31; wval = pc4; r.next_pc = jtgt;
                end
                default: r.recognized = 1'b0;
            endcase
        end
        if (wr && widx != 0) begin
            arch_regs[widx] = wval;
            r.reg_write = 1; r.reg_index = widx; r.reg_value = wval;
        end
        arch_pc = r.next_pc;
        return r;
    endfunction

    // Sends one instruction item, predicting at acceptance.
    // Valid stays high into the next item; drain() drops it.
    task automatic send_instr(logic [31:0] iw);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_instr_word <= iw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(execute_instr(iw));
        @(negedge aclk);
    endtask

    task automatic write_start_address(logic [31:0] addr);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= REG_START_ADDRESS; pwdata <= addr;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        arch_pc = addr & ~32'd3;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // Result checker and receiver stall generator.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected");
                failed = 1;
            end else begin
                exec_result_t e;
                e = pending_results.pop_front();
                if (got.next_pc !== e.next_pc) begin
                    $error("next_pc exp %h got %h", e.next_pc, got.next_pc); failed = 1;
                end
                if (got.reg_write !== e.reg_write) begin
                    $error("reg_write exp %h got %h", e.reg_write, got.reg_write); failed = 1;
                end
                if (got.reg_index !== e.reg_index) begin
                    $error("reg_index exp %h got %h", e.reg_index, got.reg_index); failed = 1;
                end
                if (got.reg_value !== e.reg_value) begin
                    $error("reg_value exp %h got %h", e.reg_value, got.reg_value); failed = 1;
                end
                if (got.mem_write !== e.mem_write) begin
                    $error("mem_write exp %h got %h", e.mem_write, got.mem_write); failed = 1;
                end
                if (got.mem_address !== e.mem_address) begin
                    $error("mem_address exp %h got %h", e.mem_address, got.mem_address);
                    failed = 1;
                end
                if (got.mem_data !== e.mem_data) begin
                    $error("mem_data exp %h got %h", e.mem_data, got.mem_data); failed = 1;
                end
                if (got.recognized !== e.recognized) begin
                    $error("recognized exp %h got %h", e.recognized, got.recognized); failed = 1;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] r_type(logic [4:0] rs, rt, rd, sa, logic [5:0] fn);
        return {mseu_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Random instruction, mostly well-formed with some noise; loads only hit words already stored.
    function automatic logic [31:0] random_instr();
        logic [5:0] fns [13];
        logic [5:0] ops [9];
        logic [4:0] rs, rt;
        logic [31:0] addr;
        int k;
        fns = '{mseu_pkg::FN_SLL, mseu_pkg::FN_SRL, mseu_pkg::FN_JR,
                mseu_pkg::FN_MFHI, mseu_pkg::FN_MFLO, mseu_pkg::FN_MULT,
                mseu_pkg::FN_DIV, mseu_pkg::FN_ADD, mseu_pkg::FN_SUB,
                mseu_pkg::FN_AND, mseu_pkg::FN_OR, mseu_pkg::FN_XOR,
                mseu_pkg::FN_SLT};
        ops = '{mseu_pkg::OP_J, mseu_pkg::OP_JAL, mseu_pkg::OP_BEQ,
                mseu_pkg::OP_BNE, mseu_pkg::OP_BLEZ, mseu_pkg::OP_BGTZ,
                mseu_pkg::OP_ADDI, mseu_pkg::OP_LUI, mseu_pkg::OP_SW};
        rs = 5'($urandom); rt = 5'($urandom);
        k = $urandom_range(99, 0);
        if (k < 45)
            return {mseu_pkg::OP_SPECIAL, $urandom_range(31, 0) == 0 ? 5'd1 : rs, rt,
                    5'($urandom), 5'($urandom), fns[$urandom_range(12, 0)]};
        if (k < 88)
            return i_type(ops[$urandom_range(8, 0)], rs, rt, 16'($urandom));
        if (k < 96) begin
            // load: pick offset so the word was stored before
            addr = arch_regs[rs] + sext16(16'($urandom));
            if (arch_mem_written[mem_slot(addr)])
                return i_type(mseu_pkg::OP_LW, rs, rt, 16'(addr - arch_regs[rs]));
            for (int i = 0; i < 64; i++) begin
                logic [15:0] off;
                off = 16'($urandom);
                if (arch_mem_written[mem_slot(arch_regs[rs] + sext16(off))])
                    return i_type(mseu_pkg::OP_LW, rs, rt, off);
            end
            return i_type(mseu_pkg::OP_SW, rs, rt, 16'($urandom));
        end
        // noise: random words, mostly unknown opcodes or functions (LW excluded)
        do begin
            addr = $urandom;
        end while (addr[31:26] == mseu_pkg::OP_LW);
        return addr;
    endfunction

    task automatic test_directed();
        send_idle_pct = 0; recv_stall_pct = 0;
        send_instr(i_type(mseu_pkg::OP_LUI, 0, 1, 16'h8000));   // r1 = min int
        send_instr(i_type(mseu_pkg::OP_ADDI, 0, 2, 16'hFFFF));  // r2 = -1
        send_instr(i_type(mseu_pkg::OP_ADDI, 0, 3, 16'h7FFF));
        send_instr(r_type(1, 2, 4, 0, mseu_pkg::FN_ADD));       // wrap
        send_instr(r_type(1, 3, 5, 0, mseu_pkg::FN_SUB));
        send_instr(r_type(1, 2, 0, 0, mseu_pkg::FN_MULT));
        send_instr(r_type(0, 0, 6, 0, mseu_pkg::FN_MFHI));
        send_instr(r_type(0, 0, 7, 0, mseu_pkg::FN_MFLO));
        send_instr(r_type(1, 2, 0, 0, mseu_pkg::FN_DIV));       // min / -1
        send_instr(r_type(0, 0, 6, 0, mseu_pkg::FN_MFLO));
        send_instr(r_type(3, 0, 0, 0, mseu_pkg::FN_DIV));       // divide by zero
        send_instr(r_type(0, 0, 7, 0, mseu_pkg::FN_MFHI));
        send_instr(r_type(0, 1, 8, 31, mseu_pkg::FN_SLL));
        send_instr(r_type(1, 2, 9, 31, mseu_pkg::FN_SRL));      // rotate
        send_instr(r_type(0, 1, 9, 0, mseu_pkg::FN_SRL));
        send_instr(r_type(1, 3, 10, 0, mseu_pkg::FN_SLT));
        send_instr(r_type(2, 3, 11, 0, mseu_pkg::FN_AND) | 32'h0 | mseu_pkg::FN_XOR);
        send_instr(i_type(mseu_pkg::OP_ADDI, 0, 0, 16'h1234));  // r0 dropped
        send_instr(i_type(mseu_pkg::OP_SW, 2, 3, 16'h8000));
        send_instr(i_type(mseu_pkg::OP_LW, 2, 12, 16'h8000));
        send_instr(i_type(mseu_pkg::OP_BEQ, 1, 1, 16'h8000));
        send_instr(i_type(mseu_pkg::OP_BNE, 1, 2, 16'h7FFF));
        send_instr(i_type(mseu_pkg::OP_BGTZ, 3, 0, 16'h0004));
        send_instr(i_type(mseu_pkg::OP_BLEZ, 1, 0, 16'hFFFC));
        send_instr({mseu_pkg::OP_JAL, 26'h3FF_FFFF});
        send_instr({mseu_pkg::OP_J, 26'h0});
        send_instr(r_type(1, 0, 0, 0, mseu_pkg::FN_JR));
        send_instr(32'hFFFF_FFFF);                               // unknown
        send_instr(r_type(0, 0, 0, 0, 6'h3F));                   // unknown fn
        drain();
    endtask

    task automatic test_random_phase(int n, int gap, int stall, logic [31:0] start);
        write_start_address(start);
        send_idle_pct = gap; recv_stall_pct = stall;
        repeat (n) send_instr(random_instr());
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off_cycles = 300;
        repeat (20) send_instr(random_instr());
        drain();
    endtask

    initial begin
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (arch_mem[i]) begin
            arch_mem[i] = '0; arch_mem_written[i] = 0;
        end
        arch_hi = '0; arch_lo = '0; arch_pc = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random_phase(500, 0, 0, 32'hFFFF_FFFF);
        test_random_phase(500, 47, 0, 32'h0000_0000);
        test_random_phase(500, 0, 47, 32'h8000_0002);
        test_random_phase(500, 23, 23, 32'h1234_5678);
        test_backpressure();
        if (!failed && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
hdl/mseu_pkg.sv
hdl/mseu_div.sv
hdl/mseu_datapath.sv
hdl/mseu_ctrl.sv
hdl/mips_subset_execute_unit_top.sv
verif/tb.sv
